// ----- rtl/fan_speed_profile_sweep_assert.svh -----
// ----------------------------------------------------------------------------
// Fan speed profile sweep - assertion macros
// Implication helpers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_PROFILE_SWEEP_ASSERT_SVH
`define FAN_SPEED_PROFILE_SWEEP_ASSERT_SVH

// same-cycle implication
`define FSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fsps: assertion violated");

// next-cycle implication
`define FSPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fsps: assertion violated");

`endif

// ----- rtl/fsps_pkg.sv -----
// ----------------------------------------------------------------------------
// Fan speed profile sweep - package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package fsps_pkg;

  localparam int unsigned SETTING_STEPS_DEF = 30;
  localparam int unsigned PADDR_W = 5;

  localparam logic [15:0] TOP_MIN_RST  = 16'd3000;
  localparam logic [15:0] TOP_MAX_RST  = 16'd20000;
  localparam logic [15:0] STEP_MIN_RST = 16'd2000;
  localparam logic [15:0] STEP_MAX_RST = 16'd10000;
  localparam logic [15:0] READ_IVL_RST = 16'd500;
  localparam logic [9:0]  FLOOR_RST    = 10'd10;

  // floor(x / 100) for 16-bit x: (x * RECIP_K) >> RECIP_SHIFT
  localparam logic [17:0] RECIP_K     = 18'd167773;
  localparam int unsigned RECIP_SHIFT = 24;

  localparam logic [15:0] ELAPSED_SAT = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_CANCEL = 2'd2
  } action_e;

  localparam logic [2:0] ST_NONE        = 3'd0;
  localparam logic [2:0] ST_CANCELLED   = 3'd1;
  localparam logic [2:0] ST_NO_RPM      = 3'd2;
  localparam logic [2:0] ST_STALL       = 3'd3;
  localparam logic [2:0] ST_NEVER_STOPS = 3'd4;

  localparam logic [2:0] REG_TOP_MIN  = 3'd0;
  localparam logic [2:0] REG_TOP_MAX  = 3'd1;
  localparam logic [2:0] REG_STEP_MIN = 3'd2;
  localparam logic [2:0] REG_STEP_MAX = 3'd3;
  localparam logic [2:0] REG_READ_IVL = 3'd4;
  localparam logic [2:0] REG_FLOOR    = 3'd5;

  typedef struct packed {
    logic [15:0] top_min;
    logic [15:0] top_max;
    logic [15:0] step_min;
    logic [15:0] step_max;
    logic [15:0] read_interval;
    logic [9:0]  steady_floor;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  fan_setting;
    logic        setting_changed;
    logic        running;
    logic        record_valid;
    logic [4:0]  record_setting;
    logic [15:0] record_rpm;
    logic [2:0]  finish_status;
    logic [4:0]  stall_setting;
    logic [15:0] top_speed_rpm;
    logic [15:0] slowest_rpm;
    logic [6:0]  progress_percent;
  } rsp_t;

endpackage

// ----- rtl/fsps_if.sv -----
// ----------------------------------------------------------------------------
// Fan speed profile sweep - channel interfaces
// Request channel (actions and tach) and result channel.
// ----------------------------------------------------------------------------
interface fsps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] tach_rpm;

  modport source (output valid, action, tach_rpm, input ready);
  modport sink   (input valid, action, tach_rpm, output ready);
endinterface

interface fsps_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  fan_setting;
  logic        setting_changed;
  logic        running;
  logic        record_valid;
  logic [4:0]  record_setting;
  logic [15:0] record_rpm;
  logic [2:0]  finish_status;
  logic [4:0]  stall_setting;
  logic [15:0] top_speed_rpm;
  logic [15:0] slowest_rpm;
  logic [6:0]  progress_percent;

  modport source (
    output valid, fan_setting, setting_changed, running, record_valid, record_setting,
           record_rpm, finish_status, stall_setting, top_speed_rpm, slowest_rpm,
           progress_percent,
    input  ready
  );
  modport sink (
    input  valid, fan_setting, setting_changed, running, record_valid, record_setting,
           record_rpm, finish_status, stall_setting, top_speed_rpm, slowest_rpm,
           progress_percent,
    output ready
  );
endinterface

// ----- rtl/fsps_core.sv -----
// ----------------------------------------------------------------------------
// Fan speed profile sweep - sequencer core
// Sweep state registers and the per-transaction next-state logic.
// ----------------------------------------------------------------------------
module fsps_core #(
  parameter int unsigned SettingSteps = fsps_pkg::SETTING_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fsps_pkg::cfg_t cfg_i,
  input  logic           accept_i,
  input  logic [1:0]     action_i,
  input  logic [15:0]    tach_rpm_i,
  output fsps_pkg::rsp_t rsp_o
);
  import fsps_pkg::*;

  localparam int unsigned LvlW     = $clog2(SettingSteps + 1);
  localparam int unsigned LutDepth = 2 ** LvlW;
  localparam logic [LvlW-1:0] TopLvl = LvlW'(SettingSteps);

  logic [6:0] pct_lut [LutDepth];

  for (genvar gi = 0; gi < LutDepth; gi++) begin : g_pct
    localparam int unsigned PctVal =
      (gi <= SettingSteps) ? (SettingSteps - gi) * 100 / (SettingSteps + 1) : 0;
    assign pct_lut[gi] = 7'(PctVal);
  end

  logic            active_q, active_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic            pv_q, pv_d;
  logic [15:0]     prior_q, prior_d;
  logic [15:0]     elapsed_q, elapsed_d;
  logic [16:0]     next_at_q, next_at_d;
  logic [15:0]     full_q, full_d;
  logic [15:0]     lowest_q, lowest_d;

  logic [15:0] el_inc;
  logic        due;
  logic [33:0] prod;
  logic [9:0]  quo;
  logic [9:0]  limit;
  logic [15:0] diff;
  logic        steady;
  logic        at_top;
  logic [15:0] max_ms;
  logic [16:0] sum;
  logic [15:0] rpm;

  assign el_inc = (elapsed_q == ELAPSED_SAT) ? elapsed_q : elapsed_q + 16'd1;
  assign due    = ({1'b0, el_inc} >= next_at_q) || (el_inc == ELAPSED_SAT);
  assign prod   = 34'(prior_q) * 34'(RECIP_K);
  assign quo    = prod[RECIP_SHIFT +: 10];
  assign limit  = (quo < cfg_i.steady_floor) ? cfg_i.steady_floor : quo;
  assign diff   = (tach_rpm_i >= prior_q) ? tach_rpm_i - prior_q : prior_q - tach_rpm_i;
  assign steady = pv_q && (diff <= {6'd0, limit});
  assign at_top = (lvl_q == TopLvl);
  assign max_ms = at_top ? cfg_i.top_max : cfg_i.step_max;
  assign sum    = {1'b0, tach_rpm_i} + {1'b0, prior_q};
  assign rpm    = pv_q ? sum[16:1] : tach_rpm_i;

  always_comb begin
    active_d  = active_q;
    lvl_d     = lvl_q;
    pv_d      = pv_q;
    prior_d   = prior_q;
    elapsed_d = elapsed_q;
    next_at_d = next_at_q;
    full_d    = full_q;
    lowest_d  = lowest_q;
    rsp_o     = '0;
    rsp_o.finish_status = ST_NONE;

    if (accept_i) begin
      case (action_i)
        ACT_START: begin
          if (!active_q) begin
            active_d  = 1'b1;
            full_d    = '0;
            lowest_d  = '0;
            lvl_d     = TopLvl;
            pv_d      = 1'b0;
            prior_d   = '0;
            elapsed_d = '0;
            next_at_d = {1'b0, cfg_i.top_min};
            rsp_o.setting_changed = 1'b1;
          end
        end
        ACT_CANCEL: begin
          if (active_q) begin
            active_d = 1'b0;
            rsp_o.finish_status = ST_CANCELLED;
          end
        end
        ACT_TICK: begin
          if (active_q) begin
            elapsed_d = el_inc;
            if (due) begin
              if (!steady && (el_inc < max_ms)) begin
                prior_d   = tach_rpm_i;
                pv_d      = 1'b1;
                next_at_d = {1'b0, el_inc} + {1'b0, cfg_i.read_interval};
              end else begin
                rsp_o.record_valid   = 1'b1;
                rsp_o.record_setting = 5'(lvl_q);
                rsp_o.record_rpm     = rpm;
                pv_d    = 1'b0;
                prior_d = '0;
                if (at_top) begin
                  full_d = rpm;
                end
                if (rpm != '0) begin
                  lowest_d = rpm;
                end
                if (at_top && (rpm == '0)) begin
                  active_d = 1'b0;
                  rsp_o.finish_status = ST_NO_RPM;
                end else if ((rpm == '0) || (lvl_q == '0)) begin
                  active_d = 1'b0;
                  if (rpm == '0) begin
                    rsp_o.stall_setting = 5'(lvl_q + LvlW'(1));
                    rsp_o.finish_status = ST_STALL;
                  end else begin
                    rsp_o.finish_status = ST_NEVER_STOPS;
                  end
                end else begin
                  lvl_d     = lvl_q - LvlW'(1);
                  elapsed_d = '0;
                  next_at_d = {1'b0, cfg_i.step_min};
                  rsp_o.setting_changed = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    rsp_o.fan_setting      = active_d ? 5'(lvl_d) : 5'd0;
    rsp_o.running          = active_d;
    rsp_o.top_speed_rpm    = full_d;
    rsp_o.slowest_rpm      = lowest_d;
    rsp_o.progress_percent = active_d ? pct_lut[lvl_d] : 7'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      lvl_q     <= '0;
      pv_q      <= 1'b0;
      prior_q   <= '0;
      elapsed_q <= '0;
      next_at_q <= '0;
      full_q    <= '0;
      lowest_q  <= '0;
    end else begin
      active_q  <= active_d;
      lvl_q     <= lvl_d;
      pv_q      <= pv_d;
      prior_q   <= prior_d;
      elapsed_q <= elapsed_d;
      next_at_q <= next_at_d;
      full_q    <= full_d;
      lowest_q  <= lowest_d;
    end
  end

endmodule

// ----- rtl/fsps_obuf.sv -----
// ----------------------------------------------------------------------------
// Fan speed profile sweep - result buffer
// Output register plus skid entry; decouples the result stall from intake.
// ----------------------------------------------------------------------------
module fsps_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fsps_pkg::rsp_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fsps_pkg::rsp_t pop_data_o
);
  import fsps_pkg::*;

  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  rsp_t main_q, main_d;
  rsp_t skid_q, skid_d;
  logic take;

  assign take         = main_vld_q && pop_ready_i;
  assign push_ready_o = !skid_vld_q;
  assign pop_valid_o  = main_vld_q;
  assign pop_data_o   = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (!main_vld_q || take) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        main_d     = push_data_i;
        main_vld_d = push_i;
      end
    end else if (push_i) begin
      skid_d     = push_data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ----- rtl/fan_speed_profile_sweep.sv -----
// ----------------------------------------------------------------------------
// Fan speed profile sweep - top level
// Sweeps a fan from full drive down to stall or setting zero, recording speeds.
// ----------------------------------------------------------------------------
// Channels: req_i takes one action per transaction (tick carrying the tach
// reading, start, cancel); rsp_o returns exactly one result per request, in
// order. The user must write configuration over the APB-style port only while
// idle; the block does not enforce it. pready is tied high and reads return
// the stored register value. Result path: a result is registered and is on
// rsp_o in the cycle after its request if no earlier result waits, else once
// the earlier one is taken. Throughput: one request per cycle while req_i is
// ready; all next-state work is one pass through the core logic between the
// sweep state registers and the result register. Stall: a two-entry result
// buffer keeps req_i ready while one result waits; ready drops only when both
// entries are full. Reset: sweep idle, all speeds zero, timing registers at
// their defaults, result buffer empty.
// ----------------------------------------------------------------------------
module fan_speed_profile_sweep #(
  parameter int unsigned SettingSteps = fsps_pkg::SETTING_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  fsps_in_if.sink                      req_i,
  fsps_out_if.source                   rsp_o
);
  import fsps_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       req_ready;
  logic       accept;
  rsp_t       core_rsp;
  rsp_t       buf_rsp;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_min       <= TOP_MIN_RST;
      cfg_q.top_max       <= TOP_MAX_RST;
      cfg_q.step_min      <= STEP_MIN_RST;
      cfg_q.step_max      <= STEP_MAX_RST;
      cfg_q.read_interval <= READ_IVL_RST;
      cfg_q.steady_floor  <= FLOOR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TOP_MIN:  cfg_q.top_min       <= pwdata[15:0];
        REG_TOP_MAX:  cfg_q.top_max       <= pwdata[15:0];
        REG_STEP_MIN: cfg_q.step_min      <= pwdata[15:0];
        REG_STEP_MAX: cfg_q.step_max      <= pwdata[15:0];
        REG_READ_IVL: cfg_q.read_interval <= pwdata[15:0];
        REG_FLOOR:    cfg_q.steady_floor  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TOP_MIN:  prdata = {16'd0, cfg_q.top_min};
      REG_TOP_MAX:  prdata = {16'd0, cfg_q.top_max};
      REG_STEP_MIN: prdata = {16'd0, cfg_q.step_min};
      REG_STEP_MAX: prdata = {16'd0, cfg_q.step_max};
      REG_READ_IVL: prdata = {16'd0, cfg_q.read_interval};
      REG_FLOOR:    prdata = {22'd0, cfg_q.steady_floor};
      default:      prdata = '0;
    endcase
  end

  assign req_i.ready = req_ready;
  assign accept      = req_i.valid && req_ready;

  fsps_core #(
    .SettingSteps(SettingSteps)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .action_i   (req_i.action),
    .tach_rpm_i (req_i.tach_rpm),
    .rsp_o      (core_rsp)
  );

  fsps_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_data_i  (core_rsp),
    .push_ready_o (req_ready),
    .pop_valid_o  (rsp_o.valid),
    .pop_ready_i  (rsp_o.ready),
    .pop_data_o   (buf_rsp)
  );

  assign rsp_o.fan_setting      = buf_rsp.fan_setting;
  assign rsp_o.setting_changed  = buf_rsp.setting_changed;
  assign rsp_o.running          = buf_rsp.running;
  assign rsp_o.record_valid     = buf_rsp.record_valid;
  assign rsp_o.record_setting   = buf_rsp.record_setting;
  assign rsp_o.record_rpm       = buf_rsp.record_rpm;
  assign rsp_o.finish_status    = buf_rsp.finish_status;
  assign rsp_o.stall_setting    = buf_rsp.stall_setting;
  assign rsp_o.top_speed_rpm    = buf_rsp.top_speed_rpm;
  assign rsp_o.slowest_rpm      = buf_rsp.slowest_rpm;
  assign rsp_o.progress_percent = buf_rsp.progress_percent;

endmodule

// ----- rtl/fsps_checker.sv -----
// ----------------------------------------------------------------------------
// Fan speed profile sweep - port checker
// Flow checks between the request and result channels.
// ----------------------------------------------------------------------------
`include "fan_speed_profile_sweep_assert.svh"

module fsps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        record_valid_i,
  input logic [15:0] record_rpm_i,
  input logic [2:0]  finish_status_i
);

  // intake only backs up when results are waiting
  `FSPS_ASSERT_IMP(a_ready_only_blocked, clk_i, rst_ni, !in_ready_i, out_valid_i)

  // a full buffer that drains one result reopens intake
  `FSPS_ASSERT_NXT(a_drain_reopens, clk_i, rst_ni, !in_ready_i && out_ready_i, in_ready_i)

  // every transaction yields a result
  `FSPS_ASSERT_NXT(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i)

  `FSPS_ASSERT_NXT(a_result_held, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(record_valid_i) && $stable(record_rpm_i) &&
    $stable(finish_status_i))

endmodule

bind fan_speed_profile_sweep fsps_checker u_fsps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .record_valid_i  (rsp_o.record_valid),
  .record_rpm_i    (rsp_o.record_rpm),
  .finish_status_i (rsp_o.finish_status)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed profile sweep - testbench
// The testbench sends start, cancel and tick transactions that carry tach
// readings, with random gaps on the request side and random stalls on the
// result side. A behavioral copy of the sweep sequencer predicts every
// result, and the monitor compares each one field by field, in order. The
// timing registers are rewritten over APB between phases and read back. The
// run covers zero settings, mid-range settings and full-scale settings.
// ----------------------------------------------------------------------------
module testbench;
  import fsps_pkg::*;

  localparam int unsigned STEPS       = SETTING_STEPS_DEF;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] tach;
  } fan_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  fsps_in_if  req_bus ();
  fsps_out_if rsp_bus ();

  fan_speed_profile_sweep i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // sweep model state
  cfg_t        timing;
  logic        sweep_on;
  logic [4:0]  drive;
  logic        prior_ok;
  logic [15:0] prior;
  logic [15:0] elapsed;
  logic [16:0] next_at;
  logic [15:0] full_rpm;
  logic [15:0] low_rpm;

  fan_req_t    stim_q[$];
  rsp_t        expected_q[$];
  bit          req_fire;
  bit          gaps_on;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned n_items;
  int unsigned n_records;
  int unsigned n_finish[8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic enter_level(input logic [4:0] lvl, input logic [15:0] settle);
    drive    = lvl;
    prior_ok = 1'b0;
    prior    = '0;
    elapsed  = '0;
    next_at  = {1'b0, settle};
  endtask

  task automatic predict_result(input logic [1:0] act, input logic [15:0] tach,
                                output rsp_t r);
    logic        steady;
    logic [15:0] lim;
    logic [15:0] diff;
    logic [15:0] max_ms;
    logic [15:0] rpm;
    r = '0;
    case (act)
      ACT_START: if (!sweep_on) begin
        sweep_on = 1'b1;
        full_rpm = '0;
        low_rpm  = '0;
        enter_level(5'(STEPS), timing.top_min);
        r.setting_changed = 1'b1;
      end
      ACT_CANCEL: if (sweep_on) begin
        sweep_on        = 1'b0;
        r.finish_status = ST_CANCELLED;
      end
      ACT_TICK: if (sweep_on) begin
        if (elapsed != ELAPSED_SAT) elapsed++;
        if ({1'b0, elapsed} >= next_at || elapsed == ELAPSED_SAT) begin
          steady = 1'b0;
          if (prior_ok) begin
            lim = prior / 16'd100;
            if (lim < {6'd0, timing.steady_floor}) lim = {6'd0, timing.steady_floor};
            diff   = (tach >= prior) ? tach - prior : prior - tach;
            steady = (diff <= lim);
          end
          max_ms = (drive == 5'(STEPS)) ? timing.top_max : timing.step_max;
          if (!steady && elapsed < max_ms) begin
            prior    = tach;
            prior_ok = 1'b1;
            next_at  = {1'b0, elapsed} + {1'b0, timing.read_interval};
          end else begin
            rpm = prior_ok ? 16'(({1'b0, tach} + {1'b0, prior}) >> 1) : tach;
            r.record_valid   = 1'b1;
            r.record_setting = drive;
            r.record_rpm     = rpm;
            prior_ok = 1'b0;
            prior    = '0;
            if (drive == 5'(STEPS)) full_rpm = rpm;
            if (rpm != '0) low_rpm = rpm;
            if (drive == 5'(STEPS) && rpm == '0) begin
              sweep_on        = 1'b0;
              r.finish_status = ST_NO_RPM;
            end else if (rpm == '0 || drive == '0) begin
              sweep_on = 1'b0;
              if (rpm == '0) begin
                r.stall_setting = drive + 5'd1;
                r.finish_status = ST_STALL;
              end else begin
                r.finish_status = ST_NEVER_STOPS;
              end
            end else begin
              enter_level(drive - 5'd1, timing.step_min);
              r.setting_changed = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.fan_setting      = sweep_on ? drive : '0;
    r.running          = sweep_on;
    r.top_speed_rpm    = full_rpm;
    r.slowest_rpm      = low_rpm;
    r.progress_percent = sweep_on ? 7'((STEPS - drive) * 100 / (STEPS + 1)) : '0;
  endtask

  // request side: acceptance at the rising edge, driving at the falling edge
  always @(posedge clk_i) begin : req_accept
    rsp_t r;
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      predict_result(req_bus.action, req_bus.tach_rpm, r);
      expected_q.push_back(r);
      n_items++;
      if (r.record_valid) n_records++;
      n_finish[r.finish_status]++;
      req_fire = 1'b1;
    end
  end

  always @(negedge clk_i) begin : req_drive
    if (req_fire) begin
      void'(stim_q.pop_front());
      req_fire = 1'b0;
      if (gaps_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
    end
    if (send_gap > 0) begin
      send_gap--;
      req_bus.valid <= 1'b0;
    end else if (stim_q.size() > 0) begin
      req_bus.valid    <= 1'b1;
      req_bus.action   <= stim_q[0].action;
      req_bus.tach_rpm <= stim_q[0].tach;
    end else begin
      req_bus.valid <= 1'b0;
    end
  end

  // result side
  always @(negedge clk_i) begin : rsp_ready_drive
    if (recv_gap > 0) begin
      recv_gap--;
      rsp_bus.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 19) - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no request outstanding");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("fan_setting", 16'(want.fan_setting), 16'(rsp_bus.fan_setting));
        check_field("setting_changed", 16'(want.setting_changed),
                    16'(rsp_bus.setting_changed));
        check_field("running", 16'(want.running), 16'(rsp_bus.running));
        check_field("record_valid", 16'(want.record_valid), 16'(rsp_bus.record_valid));
        check_field("record_setting", 16'(want.record_setting),
                    16'(rsp_bus.record_setting));
        check_field("record_rpm", want.record_rpm, rsp_bus.record_rpm);
        check_field("finish_status", 16'(want.finish_status), 16'(rsp_bus.finish_status));
        check_field("stall_setting", 16'(want.stall_setting), 16'(rsp_bus.stall_setting));
        check_field("top_speed_rpm", want.top_speed_rpm, rsp_bus.top_speed_rpm);
        check_field("slowest_rpm", want.slowest_rpm, rsp_bus.slowest_rpm);
        check_field("progress_percent", 16'(want.progress_percent),
                    16'(rsp_bus.progress_percent));
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    logic [31:0] want;
    want = (idx == REG_FLOOR) ? {22'd0, val[9:0]} : {16'd0, val};
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_TOP_MIN:  timing.top_min       = val;
      REG_TOP_MAX:  timing.top_max       = val;
      REG_STEP_MIN: timing.step_min      = val;
      REG_STEP_MAX: timing.step_max      = val;
      REG_READ_IVL: timing.read_interval = val;
      REG_FLOOR:    timing.steady_floor  = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("register %0d readback: expected %0h, got %0h", idx, want, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] top_min, input logic [15:0] top_max,
                            input logic [15:0] step_min, input logic [15:0] step_max,
                            input logic [15:0] ivl, input logic [9:0] floor_rpm);
    write_reg(REG_TOP_MIN, top_min);
    write_reg(REG_TOP_MAX, top_max);
    write_reg(REG_STEP_MIN, step_min);
    write_reg(REG_STEP_MAX, step_max);
    write_reg(REG_READ_IVL, ivl);
    write_reg(REG_FLOOR, {6'd0, floor_rpm});
  endtask

  task automatic queue_item(input logic [1:0] act, input logic [15:0] tach);
    fan_req_t item;
    item.action = act;
    item.tach   = tach;
    stim_q.push_back(item);
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one sweep with a tach profile: drifting down, stalling, noisy or dead
  task automatic queue_sweep(output int unsigned count);
    int unsigned mode;
    int unsigned ticks;
    int unsigned stall_at;
    int unsigned lvl;
    int unsigned dec;
    int unsigned jit;
    int unsigned v;
    int unsigned k;
    logic [15:0] tach;
    mode     = $urandom_range(0, 3);
    ticks    = $urandom_range(10, 120);
    stall_at = $urandom_range(4, ticks);
    lvl      = $urandom_range(200, 65535);
    dec      = $urandom_range(0, lvl / 300);
    jit      = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 600);
    queue_item(ACT_START, 16'($urandom));
    for (k = 0; k < ticks; k++) begin
      lvl = (lvl > dec + 1) ? lvl - dec : 1;
      v   = lvl + $urandom_range(0, jit);
      tach = (v > 65535) ? 16'hFFFF : 16'(v);
      case (mode)
        1: if (k >= stall_at) tach = '0;
        2: tach = 16'($urandom);
        3: tach = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd0;
        default: ;
      endcase
      queue_item(ACT_TICK, tach);
    end
    count = ticks + 1;
    if ($urandom_range(0, 2) == 0) begin
      queue_item(ACT_CANCEL, 16'($urandom));
      count++;
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned queued;
    int unsigned n;
    int unsigned k;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_bus.valid    = 1'b0;
    req_bus.action   = ACT_TICK;
    req_bus.tach_rpm = '0;
    rsp_bus.ready    = 1'b0;
    gaps_on          = 1'b1;
    timing   = {TOP_MIN_RST, TOP_MAX_RST, STEP_MIN_RST, STEP_MAX_RST, READ_IVL_RST, FLOOR_RST};
    sweep_on = 1'b0;
    drive    = '0;
    prior_ok = 1'b0;
    prior    = '0;
    elapsed  = '0;
    next_at  = '0;
    full_rpm = '0;
    low_rpm  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle and ignored actions, plus a start and a cancel, at reset timing
    queue_item(ACT_TICK, 16'hFFFF);
    queue_item(ACT_CANCEL, 16'h0000);
    queue_item(ACT_UNUSED, 16'hAAAA);
    queue_item(ACT_START, 16'h5555);
    queue_item(ACT_START, 16'h0000);
    queue_item(ACT_UNUSED, 16'hFFFF);
    queue_item(ACT_TICK, 16'h5555);
    queue_item(ACT_CANCEL, 16'h1234);
    queue_item(ACT_TICK, 16'h4321);
    wait_idle();

    // full-scale agreement, stall, no rpm at full drive, timeout
    set_timing(16'd1, 16'd4, 16'd1, 16'd3, 16'd1, 10'd0);
    queue_item(ACT_START, 16'd0);
    queue_item(ACT_TICK, 16'hFFFF);
    queue_item(ACT_TICK, 16'hFFFF);
    queue_item(ACT_TICK, 16'd0);
    queue_item(ACT_TICK, 16'd0);
    queue_item(ACT_START, 16'd0);
    queue_item(ACT_TICK, 16'd0);
    queue_item(ACT_TICK, 16'd0);
    queue_item(ACT_START, 16'd0);
    queue_item(ACT_TICK, 16'd100);
    queue_item(ACT_TICK, 16'd300);
    queue_item(ACT_TICK, 16'd500);
    queue_item(ACT_TICK, 16'd700);
    queue_item(ACT_CANCEL, 16'd0);
    wait_idle();

    // zero settle and interval
    set_timing(16'd0, 16'd2, 16'd0, 16'd2, 16'd0, 10'd0);
    queue_item(ACT_START, 16'd0);
    queue_item(ACT_TICK, 16'd500);
    queue_item(ACT_TICK, 16'd800);
    queue_item(ACT_TICK, 16'd0);
    queue_item(ACT_TICK, 16'd0);
    wait_idle();

    // full-scale timing: the next sample time runs past 16 bits
    set_timing(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
    queue_item(ACT_START, 16'd0);
    for (k = 0; k < 8; k++) queue_item(ACT_TICK, 16'($urandom_range(20000, 20500)));
    queue_item(ACT_CANCEL, 16'd0);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      gaps_on = (ph != 5);
      set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 10)),
                 16'($urandom_range(1, 3)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 3)),
                 (ph == 0) ? 10'd0 : (ph == 1) ? 10'h3FF : 10'($urandom_range(0, 1023)));
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_item(2'($urandom), 16'($urandom));
        end else begin
          queue_sweep(n);
          queued += n;
        end
      end
      wait_idle();
    end

    $display("%0d transactions checked, %0d speed records emitted", n_items, n_records);
    $display("sweep ends: %0d cancelled, %0d no rpm at full, %0d stalled, %0d never stopped",
             n_finish[ST_CANCELLED], n_finish[ST_NO_RPM], n_finish[ST_STALL],
             n_finish[ST_NEVER_STOPS]);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
